>>> hw/rtl/hotp_pkg.sv
// Package for the HMAC-SHA1 one-time-code verifier: shared types, SHA-1 constants.
// Used by hotp_sha1_core, hotp_mod_unit and hmac_sha1_otp_verifier.
package hotp_pkg;

   typedef enum logic [2:0] {
      CSR_KEY_LOW     = 3'd0,
      CSR_KEY_MID     = 3'd1,
      CSR_KEY_TOP     = 3'd2,
      CSR_KEY_LENGTH  = 3'd3,
      CSR_CODE_DIGITS = 3'd4,
      CSR_DRIFT       = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NEXT,
      ST_BLK_START,
      ST_BLK_WAIT,
      ST_TRUNC,
      ST_MOD_WAIT,
      ST_EVAL,
      ST_DONE
   } state_type;

   // Phase of the four compressions that make up one HMAC
   typedef enum logic [1:0] {
      PH_IPAD  = 2'd0,
      PH_MSG   = 2'd1,
      PH_OPAD  = 2'd2,
      PH_OUTER = 2'd3
   } phase_type;

   typedef struct packed {
      logic start;
      logic init;
   } sha_ctl_type;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
   localparam logic [31:0] K_R0 = 32'h5A827999;
   localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_R3 = 32'hCA62C1D6;
   localparam logic [7:0]  IPAD_BYTE = 8'h36;
   localparam logic [7:0]  OPAD_BYTE = 8'h5c;
   localparam logic [7:0]  TRUNC_MASK = 8'h7F;

   // Ten to the power d, d clamped to 1..9
   function automatic logic [29:0] pow10(input logic [3:0] d);
      logic [29:0] r;
      unique case (d)
         4'd0, 4'd1: r = 30'd10;
         4'd2: r = 30'd100;
         4'd3: r = 30'd1000;
         4'd4: r = 30'd10000;
         4'd5: r = 30'd100000;
         4'd6: r = 30'd1000000;
         4'd7: r = 30'd10000000;
         4'd8: r = 30'd100000000;
         default: r = 30'd1000000000;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/hotp_sha1_core.sv
// One SHA-1 compression, one round per cycle, over a 16-word block.
// Depends on hotp_pkg; chaining value kept here across blocks.
module hotp_sha1_core
   import hotp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sha_ctl_type  ctl,
   input  logic [511:0] block,
   output logic         done,
   output logic [159:0] digest
);

   logic [31:0]  h_ff [5];
   logic [31:0]  h_in [5];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [511:0] w_ff, w_in;
   logic [6:0]   rnd_ff, rnd_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [31:0]  f, k, t, wnew, wcur;

   assign wcur = w_ff[511:480];
   assign wnew = {w_ff[511-32*13-: 32] ^ w_ff[511-32*8-: 32] ^ w_ff[511-32*2-: 32]
                 ^ w_ff[511-: 32]};

   // Round function
   always_comb begin
      if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff); k = K_R0;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff; k = K_R1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff); k = K_R2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff; k = K_R3;
      end
      t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + wcur;
      w_in = {w_ff[479:0], wnew[30:0], wnew[31]};
   end

   always_comb begin
      busy_in = busy_ff;
      rnd_in  = rnd_ff;
      done_in = 1'b0;
      for (int i = 0; i < 5; i++) h_in[i] = h_ff[i];
      if (ctl.init) begin
         h_in[0] = H0_INIT; h_in[1] = H1_INIT; h_in[2] = H2_INIT;
         h_in[3] = H3_INIT; h_in[4] = H4_INIT;
      end
      if (ctl.start) begin
         busy_in = 1'b1;
         rnd_in  = 7'd0;
      end else if (busy_ff) begin
         rnd_in = rnd_ff + 7'd1;
         if (rnd_ff == 7'd79) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            h_in[0] = h_ff[0] + t;
            h_in[1] = h_ff[1] + a_ff;
            h_in[2] = h_ff[2] + {b_ff[1:0], b_ff[31:2]};
            h_in[3] = h_ff[3] + c_ff;
            h_in[4] = h_ff[4] + d_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff  <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         rnd_ff  <= rnd_in;
      end
   end

   // Working variables and message schedule
   always_ff @(posedge clock) begin
      for (int i = 0; i < 5; i++) h_ff[i] <= h_in[i];
      if (ctl.start) begin
         a_ff <= h_in[0]; b_ff <= h_in[1]; c_ff <= h_in[2];
         d_ff <= h_in[3]; e_ff <= h_in[4];
         w_ff <= block;
      end else if (busy_ff) begin
         e_ff <= d_ff; d_ff <= c_ff; c_ff <= {b_ff[1:0], b_ff[31:2]};
         b_ff <= a_ff; a_ff <= t;
         w_ff <= w_in;
      end
   end

   assign done   = done_ff;
   assign digest = {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};

endmodule

>>> hw/rtl/hotp_mod_unit.sv
// Restoring remainder of a 31-bit value by a 30-bit modulus, one bit a cycle.
// Depends on hotp_pkg for style only.
module hotp_mod_unit
   import hotp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] dividend,
   input  logic [29:0] modulus,
   output logic        done,
   output logic [29:0] remainder
);

   logic [30:0] rem_ff, rem_in;
   logic [30:0] num_ff, num_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[30]};
      if (start) begin
         rem_in  = '0;
         num_in  = dividend;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Shift in one bit, subtract when it fits
         if (trial >= {2'b00, modulus}) rem_in = 31'(trial - {2'b00, modulus});
         else rem_in = trial[30:0];
         num_in = {num_ff[29:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd30) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[29:0];

endmodule

>>> hw/rtl/hmac_sha1_otp_verifier.sv
// HMAC-SHA1 one-time-code verifier (counter window search); top level.
// Each counter is picked, then hashed by four SHA-1 compressions (start, 80
// rounds, done) on one shared round unit, truncated, reduced by bit-serial
// modulo and compared. A counter below zero is skipped without hashing. The
// search covers up to 2*drift_window+1 counters; a match before the centre
// jumps straight to the centre counter, so no search needs more than the full
// window. busy stays high throughout; rsp_valid pulses for one cycle and the
// receiver cannot stall it.
// Depends on hotp_pkg, hotp_sha1_core, hotp_mod_unit.
module hmac_sha1_otp_verifier
   import hotp_pkg::*;
#(
   parameter int KEY_BYTES = 20
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [62:0] req_time_step,
   input  logic [29:0] req_candidate_code,
   output logic        rsp_valid,
   output logic [29:0] rsp_centre_code,
   output logic        rsp_matched,
   output logic signed [3:0] rsp_match_offset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam logic [4:0] KEY_MAX = 5'(KEY_BYTES);

   logic [63:0] key_low_ff, key_mid_ff;
   logic [31:0] key_top_ff;
   logic [4:0]  key_length_ff;
   logic [3:0]  code_digits_ff;
   logic [2:0]  drift_ff;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [62:0] ts_ff;
   logic [29:0] cand_ff;
   logic signed [4:0] delta_ff, delta_in;
   logic        found_ff, found_in;
   logic signed [3:0] hit_ff, hit_in;
   logic [29:0] centre_ff, centre_in;
   logic        recheck_ff, recheck_in;
   logic [159:0] inner_ff;
   logic [63:0] ctr_ff, ctr_in;
   logic [30:0] bin_ff;
   logic [30:0] bin_in;
   logic        rsp_valid_ff;

   sha_ctl_type sha_ctl;
   logic [511:0] block;
   logic        sha_done, mod_done, mod_start;
   logic [159:0] digest;
   logic [29:0] code;
   logic [511:0] key_blk;
   logic [4:0]  used;
   logic [159:0] key_bytes;
   logic [29:0] modulus;
   logic signed [4:0] win;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);
   assign modulus   = pow10(code_digits_ff);
   assign win       = 5'(drift_ff);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff <= '0; key_mid_ff <= '0; key_top_ff <= '0;
         key_length_ff <= 5'd20; code_digits_ff <= 4'd6; drift_ff <= 3'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KEY_LOW:     key_low_ff <= csr_wdata;
            CSR_KEY_MID:     key_mid_ff <= csr_wdata;
            CSR_KEY_TOP:     key_top_ff <= csr_wdata[31:0];
            CSR_KEY_LENGTH:  key_length_ff <= csr_wdata[4:0];
            CSR_CODE_DIGITS: code_digits_ff <= csr_wdata[3:0];
            CSR_DRIFT:       drift_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // Key padded block: bytes beyond the used length read as zero
   always_comb begin
      used = (key_length_ff > KEY_MAX) ? KEY_MAX : key_length_ff;
      key_bytes = {key_low_ff, key_mid_ff, key_top_ff};
      for (int j = 0; j < 20; j++)
         if (5'(j) >= used) key_bytes[159-8*j -: 8] = 8'h00;
      key_blk = {key_bytes, 352'd0};
   end

   // Block for the current phase
   always_comb begin
      unique case (phase_ff)
         PH_IPAD:  block = key_blk ^ {64{IPAD_BYTE}};
         PH_MSG:   block = {ctr_ff, 32'h80000000, 384'd0, 32'd576};
         PH_OPAD:  block = key_blk ^ {64{OPAD_BYTE}};
         default:  block = {inner_ff, 32'h80000000, 288'd0, 32'd672};
      endcase
   end

   // Dynamic truncation
   always_comb begin
      logic [3:0] o;
      logic [31:0] sel;
      o = digest[3:0];
      sel = digest[159 - 8*o -: 32];
      bin_in = 31'({sel[31:24] & TRUNC_MASK, sel[23:0]});
   end

   hotp_sha1_core u_sha (
      .clock(clock), .reset(reset), .ctl(sha_ctl), .block(block),
      .done(sha_done), .digest(digest)
   );

   hotp_mod_unit u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(bin_ff),
      .modulus(modulus), .done(mod_done), .remainder(code)
   );

   // Next state
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      delta_in   = delta_ff;
      found_in   = found_ff;
      hit_in     = hit_ff;
      centre_in  = centre_ff;
      recheck_in = recheck_ff;
      ctr_in     = ctr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_NEXT; delta_in = -win; found_in = 1'b0;
               hit_in = '0; centre_in = '0; recheck_in = 1'b0;
            end
         end
         ST_NEXT: begin
            // Skip counters below zero
            if (delta_ff < 0 && {1'b0, ts_ff} < 64'(-delta_ff)) begin
               delta_in = delta_ff + 5'sd1;
            end else begin
               ctr_in = {1'b0, ts_ff} + 64'(signed'(delta_ff));
               phase_in = PH_IPAD;
               state_in = ST_BLK_START;
            end
         end
         ST_BLK_START: state_in = ST_BLK_WAIT;
         ST_BLK_WAIT: begin
            if (sha_done) begin
               if (phase_ff == PH_OUTER) state_in = ST_TRUNC;
               else begin
                  phase_in = phase_type'(phase_ff + 2'd1);
                  state_in = ST_BLK_START;
               end
            end
         end
         ST_TRUNC:    state_in = ST_MOD_WAIT;
         ST_MOD_WAIT: if (mod_done) state_in = ST_EVAL;
         ST_EVAL: begin
            if (recheck_ff) begin
               centre_in = code; state_in = ST_DONE;
            end else begin
               if (delta_ff == 0) centre_in = code;
               if (!found_ff && {2'b00, code} == {2'b00, cand_ff}) begin
                  found_in = 1'b1; hit_in = 4'(delta_ff);
               end
               if ((found_ff || code == cand_ff) && delta_ff >= 0) state_in = ST_DONE;
               else if (delta_ff == win) begin
                  state_in = ST_DONE;
               end else delta_in = delta_ff + 5'sd1;
               if (state_in == ST_EVAL) state_in = ST_NEXT;
               // A match before the centre still needs the centre code
               if ((found_ff || code == cand_ff) && delta_ff < 0 && state_in == ST_DONE) begin
                  state_in = ST_NEXT;
               end
               if (found_in && delta_ff < 0 && delta_ff + 5'sd1 > 0) begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs to the units
   always_comb begin
      sha_ctl.start = (state_ff == ST_BLK_START);
      sha_ctl.init  = (state_ff == ST_BLK_START) &&
                      (phase_ff == PH_IPAD || phase_ff == PH_OPAD);
      mod_start     = (state_ff == ST_TRUNC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= (state_ff == ST_DONE);
      end
   end

   // Transaction payload and search state
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         ts_ff <= req_time_step; cand_ff <= req_candidate_code;
      end
      phase_ff <= phase_in; ctr_ff <= ctr_in; found_ff <= found_in;
      hit_ff <= hit_in; centre_ff <= centre_in;
      // Once found before the centre, jump straight to the centre counter
      if (state_ff == ST_EVAL && !recheck_ff && found_in && delta_ff < 0) begin
         recheck_ff <= 1'b1; delta_ff <= 5'sd0;
      end else begin
         recheck_ff <= recheck_in; delta_ff <= delta_in;
      end
      if (sha_done && phase_ff == PH_MSG) inner_ff <= digest;
      if (sha_done && phase_ff == PH_OUTER) bin_ff <= bin_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_centre_code  = centre_ff;
   assign rsp_matched      = found_ff;
   assign rsp_match_offset = hit_ff;

endmodule

>>> hw/rtl/hotp_checker.sv
// Port-level checker for the one-time-code verifier, bound to the top level.
// Depends on hmac_sha1_otp_verifier ports only.
module hotp_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_matched,
   input logic signed [3:0] rsp_match_offset,
   input logic [29:0] rsp_centre_code
);

   // A transaction raises busy on the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");

   // A response strobe is never repeated back to back
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response repeated");

   // No match means zero offset
   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_matched |-> rsp_match_offset == 4'sd0)
      else $error("offset without match");

   // Centre code stays below one billion
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_centre_code < 30'd1000000000) else $error("code range");

endmodule

bind hmac_sha1_otp_verifier hotp_checker u_hotp_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_matched(rsp_matched),
   .rsp_match_offset(rsp_match_offset), .rsp_centre_code(rsp_centre_code)
);

>>> tb/tb_hmac_sha1_otp_verifier.sv
// Self-checking testbench for hmac_sha1_otp_verifier: directed table, then randomized phases.
// Holds its own HMAC-SHA1 code predictor; depends on hotp_pkg and the verifier RTL.
`timescale 1ns / 1ps

module tb_hmac_sha1_otp_verifier
   import hotp_pkg::*;
();

   localparam int CYCLE_LIMIT = 15_000_000;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 100;

   typedef struct {
      logic [29:0]       centre;
      logic              matched;
      logic signed [3:0] offset;
   } verdict_type;

   typedef struct {
      bit                is_csr;
      csr_index_type     idx;
      logic [63:0]       wdata;
      logic [62:0]       ts;
      logic [29:0]       cand;
      bit                aim;
      int                aim_off;
      bit                typed;
      verdict_type       known;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [62:0] req_time_step = '0;
   logic [29:0] req_candidate_code = '0;
   logic        rsp_valid;
   logic [29:0] rsp_centre_code;
   logic        rsp_matched;
   logic signed [3:0] rsp_match_offset;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // predictor copy of the register file
   logic [63:0] cfg_key_low = '0;
   logic [63:0] cfg_key_mid = '0;
   logic [31:0] cfg_key_top = '0;
   logic [4:0]  cfg_key_length = 5'd20;
   logic [3:0]  cfg_digits = 4'd6;
   logic [2:0]  cfg_drift = 3'd1;

   verdict_type  pending_verdicts[$];
   int           mismatches = 0;
   longint       cycles = 0;
   stim_row_type plan[$];

   hmac_sha1_otp_verifier DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_time_step(req_time_step), .req_candidate_code(req_candidate_code),
      .rsp_valid(rsp_valid), .rsp_centre_code(rsp_centre_code),
      .rsp_matched(rsp_matched), .rsp_match_offset(rsp_match_offset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // one SHA-1 compression over a 512-bit block
   function automatic logic [159:0] sha1_compress(input logic [159:0] h, input logic [511:0] blk);
      logic [31:0] w[80];
      logic [31:0] a, b, c, d, e, f, k, t;
      a = h[159:128]; b = h[127:96]; c = h[95:64]; d = h[63:32]; e = h[31:0];
      for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
      for (int i = 16; i < 80; i++) begin
         t = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
         w[i] = {t[30:0], t[31]};
      end
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d); k = K_R0;
         end else if (i < 40) begin
            f = b ^ c ^ d; k = K_R1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = K_R2;
         end else begin
            f = b ^ c ^ d; k = K_R3;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[i];
         e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
      end
      return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
   endfunction

   // truncated HMAC-SHA1 code of one counter under the current key and digits
   function automatic logic [29:0] hotp_value(input logic [63:0] ctr);
      logic [159:0] key_bytes, iv, inner, mac;
      logic [511:0] kblk;
      logic [31:0]  bin, modulus;
      int           used, digits, o;
      key_bytes = {cfg_key_low, cfg_key_mid, cfg_key_top};
      used = (cfg_key_length > 20) ? 20 : cfg_key_length;
      for (int j = 0; j < 20; j++)
         if (j >= used) key_bytes[159 - 8 * j -: 8] = 8'h00;
      kblk = {key_bytes, 352'b0};
      digits = (cfg_digits < 1) ? 1 : (cfg_digits > 9) ? 9 : cfg_digits;
      modulus = 1;
      for (int i = 0; i < digits; i++) modulus = modulus * 10;
      iv = {H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
      inner = sha1_compress(iv, kblk ^ {64{IPAD_BYTE}});
      inner = sha1_compress(inner, {ctr, 32'h80000000, 384'b0, 32'd576});
      mac = sha1_compress(iv, kblk ^ {64{OPAD_BYTE}});
      mac = sha1_compress(mac, {inner, 32'h80000000, 288'b0, 32'd672});
      o = mac[3:0];
      bin = mac[159 - 8 * o -: 32];
      bin[31:24] = bin[31:24] & TRUNC_MASK;
      return 30'(bin % modulus);
   endfunction

   // centre code plus first match scanning from the oldest counter upward
   function automatic verdict_type predict_verdict(input logic [62:0] ts,
                                                   input logic [29:0] cand);
      verdict_type v;
      logic [63:0] ctr;
      int win;
      win = cfg_drift;
      v.centre = hotp_value({1'b0, ts});
      v.matched = 1'b0;
      v.offset = '0;
      for (int dl = -win; dl <= win && !v.matched; dl++) begin
         if (dl < 0 && ts < 63'(-dl)) continue;
         ctr = {1'b0, ts} + 64'(signed'(dl));
         if (hotp_value(ctr) == cand) begin
            v.matched = 1'b1;
            v.offset = 4'(dl);
         end
      end
      return v;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // check each result strobe against the oldest expectation
   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            report("unexpected result", rsp_centre_code, -1);
         end else begin
            v = pending_verdicts.pop_front();
            if (rsp_centre_code !== v.centre) report("centre_code", rsp_centre_code, v.centre);
            if (rsp_matched !== v.matched) report("matched", rsp_matched, v.matched);
            if (rsp_match_offset !== v.offset)
               report("match_offset", rsp_match_offset, v.offset);
         end
      end
   end

   // hold start until the block takes the transaction, then queue the verdict
   task automatic send_req(input logic [62:0] ts, input logic [29:0] cand,
                           input bit typed, input verdict_type known);
      verdict_type v;
      req_time_step <= ts;
      req_candidate_code <= cand;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      v = typed ? known : predict_verdict(ts, cand);
      pending_verdicts = {pending_verdicts, v};
   endtask

   // drop start for a random gap, mostly short
   task automatic idle_gap(input bit quiet);
      int r, n;
      r = $urandom_range(0, 99);
      n = (quiet || r < 50) ? 0 : (r < 90) ? $urandom_range(1, 4) : $urandom_range(20, 60);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // wait until every result is back and the block is idle
   task automatic drain;
      start <= 1'b0;
      do @(posedge clock); while (pending_verdicts.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_KEY_LOW:     cfg_key_low = data;
         CSR_KEY_MID:     cfg_key_mid = data;
         CSR_KEY_TOP:     cfg_key_top = data[31:0];
         CSR_KEY_LENGTH:  cfg_key_length = data[4:0];
         CSR_CODE_DIGITS: cfg_digits = data[3:0];
         CSR_DRIFT:       cfg_drift = data[2:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // append one row to the directed table
   task automatic add_row(input stim_row_type r);
      plan = {plan, r};
   endtask

   // candidate equal to the code of a counter at the given offset
   function automatic logic [29:0] aimed_code(input logic [62:0] ts, input int off);
      return hotp_value({1'b0, ts} + 64'(signed'(off)));
   endfunction

   function automatic stim_row_type row_csr(input csr_index_type idx, input logic [63:0] data);
      stim_row_type r;
      r = '{idx: CSR_KEY_LOW, default: '0};
      r.is_csr = 1'b1; r.idx = idx; r.wdata = data;
      return r;
   endfunction

   function automatic stim_row_type row_req(input logic [62:0] ts, input logic [29:0] cand,
                                            input bit aim, input int aim_off);
      stim_row_type r;
      r = '{idx: CSR_KEY_LOW, default: '0};
      r.ts = ts; r.cand = cand; r.aim = aim; r.aim_off = aim_off;
      return r;
   endfunction

   function automatic stim_row_type row_known(input logic [62:0] ts, input logic [29:0] cand,
                                              input logic [29:0] centre, input logic hit,
                                              input logic signed [3:0] off);
      stim_row_type r;
      r = row_req(ts, cand, 1'b0, 0);
      r.typed = 1'b1;
      r.known.centre = centre; r.known.matched = hit; r.known.offset = off;
      return r;
   endfunction

   initial begin
      logic [62:0] ts;
      logic [29:0] cand;
      bit          last_csr, quiet;
      int          win, off, pick;
      verdict_type none;

      none = '{default: '0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero key, six digits, window one
      add_row(row_req(63'd0, 30'd0, 1'b1, 0));
      add_row(row_req(63'd1, 30'd0, 1'b1, -1));
      add_row(row_req({63{1'b1}}, 30'd0, 1'b1, 1));
      add_row(row_req(63'd12345, {30{1'b1}}, 1'b0, 0));
      // published HOTP key, exact window
      add_row(row_csr(CSR_KEY_LOW, 64'h3132333435363738));
      add_row(row_csr(CSR_KEY_MID, 64'h3930313233343536));
      add_row(row_csr(CSR_KEY_TOP, 64'h0000000037383930));
      add_row(row_csr(CSR_DRIFT, 64'd0));
      add_row(row_known(63'd0, 30'd755224, 30'd755224, 1'b1, 4'sd0));
      add_row(row_known(63'd1, 30'd287082, 30'd287082, 1'b1, 4'sd0));
      add_row(row_known(63'd2, 30'd359152, 30'd359152, 1'b1, 4'sd0));
      add_row(row_known(63'd3, 30'd0, 30'd969429, 1'b0, 4'sd0));
      // widest window and nine digits
      add_row(row_csr(CSR_DRIFT, 64'd7));
      add_row(row_csr(CSR_CODE_DIGITS, 64'd9));
      add_row(row_req(63'd3, 30'd0, 1'b1, -3));
      add_row(row_req(63'd100, 30'd0, 1'b1, -7));
      add_row(row_req({63{1'b1}} - 63'd7, 30'd0, 1'b1, 7));
      add_row(row_req({63{1'b1}}, {30{1'b1}}, 1'b0, 0));
      // clamped lengths and digits
      add_row(row_csr(CSR_KEY_LENGTH, 64'd0));
      add_row(row_csr(CSR_CODE_DIGITS, 64'd0));
      add_row(row_csr(CSR_DRIFT, 64'd2));
      add_row(row_req(63'd1, 30'd0, 1'b1, 2));
      add_row(row_req(63'd50, 30'd10, 1'b0, 0));
      add_row(row_csr(CSR_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF));
      add_row(row_csr(CSR_CODE_DIGITS, 64'd15));
      add_row(row_req(63'd77, 30'd0, 1'b1, -2));
      add_row(row_csr(CSR_KEY_LENGTH, 64'd5));
      add_row(row_req(63'd78, 30'd0, 1'b1, 1));

      // walk the directed table
      last_csr = 1'b1;
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            if (!last_csr) drain();
            csr_write(plan[i].idx, plan[i].wdata);
            last_csr = 1'b1;
         end else begin
            cand = plan[i].aim ? aimed_code(plan[i].ts, plan[i].aim_off) : plan[i].cand;
            send_req(plan[i].ts, cand, plan[i].typed, plan[i].known);
            idle_gap(1'b0);
            last_csr = 1'b0;
         end
      end
      drain();

      // randomized phases, each under fresh settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         csr_write(CSR_KEY_LOW, {$urandom, $urandom});
         csr_write(CSR_KEY_MID, {$urandom, $urandom});
         csr_write(CSR_KEY_TOP, {$urandom, $urandom});
         csr_write(CSR_KEY_LENGTH, (p == 0) ? 64'd20 : {$urandom, 27'd0, 5'($urandom_range(0, 31))});
         csr_write(CSR_CODE_DIGITS, (p == 1) ? 64'd1 : {$urandom, 28'd0, 4'($urandom_range(0, 15))});
         win = (p == 2) ? 7 : $urandom_range(0, 2);
         csr_write(CSR_DRIFT, {$urandom, 29'd0, 3'(win)});
         quiet = (p == 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) ts = 63'($urandom_range(0, 9));
            else if (pick < 3) ts = {63{1'b1}} - 63'($urandom_range(0, 7));
            else ts = 63'({$urandom, $urandom});
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               off = $urandom_range(0, 2 * win) - win;
               if (off < 0 && ts < 63'(-off)) off = 0;
               if (off > 0 && ts > {63{1'b1}} - 63'(off)) off = 0;
               cand = aimed_code(ts, off);
            end else if (pick < 8) begin
               cand = 30'($urandom_range(0, 9));
            end else begin
               cand = 30'($urandom);
            end
            send_req(ts, cand, 1'b0, none);
            if (n == ITEMS_PER_PHASE / 2) drain();
            else idle_gap(quiet);
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
